>>> rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int MAX_DIM    = 64;
    localparam int KERNEL_MAX = 5;

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int SIZE_W     = 7;
    localparam int KSIZE_W    = 3;
    localparam int MASK_W     = 25;
    localparam int CFG_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int TAP_W      = SIZE_W + 1;
    localparam int KCNT_W     = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int KIDX_W     = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX * KERNEL_MAX) : 1;

    localparam logic [SIZE_W-1:0]  RST_WIDTH  = SIZE_W'(12);
    localparam logic [SIZE_W-1:0]  RST_HEIGHT = SIZE_W'(12);
    localparam logic [MASK_W-1:0]  RST_MASK   = '1;
    localparam logic [KSIZE_W-1:0] RST_KROWS  = KSIZE_W'(5);
    localparam logic [KSIZE_W-1:0] RST_KCOLS  = KSIZE_W'(5);
    localparam logic [KSIZE_W-1:0] RST_CROW   = KSIZE_W'(2);
    localparam logic [KSIZE_W-1:0] RST_CCOL   = KSIZE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_MASK  = 3'd2,
        CFG_KERNEL_ROWS  = 3'd3,
        CFG_KERNEL_COLS  = 3'd4,
        CFG_CENTER_ROW   = 3'd5,
        CFG_CENTER_COL   = 3'd6
    } cfg_idx_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic result_load;
    } bdq_cmd_t;

    typedef struct packed {
        logic query_now;
        logic bad_now;
        logic tap_last;
        logic rsp_free;
    } bdq_status_t;

endpackage

>>> rtl/binary_dilation_query.sv
// Flow: a pixel write or an out-of-image item goes from accept straight to the output load
// state; a query first scans all 25 taps of the 5x5 element (at most one store read per tap),
// then passes a read drain state, then the output load state, after which rsp_valid rises.
// A new item is taken only in idle, once the last one has been loaded to the output; the single
// store read port serializes the taps. A waiting result holds only the next item's output load.
// Reset: async active low; config returns to defaults, the pixel store is not cleared.
module binary_dilation_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          func,
    input  logic [bdq_pkg::DIM_W-1:0]     pixel_row,
    input  logic [bdq_pkg::DIM_W-1:0]     pixel_col,
    input  logic                          pixel_value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          dilated_value,
    output logic                          bad_position
);
    import bdq_pkg::*;

    bdq_cmd_t    cmd;
    bdq_status_t status;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bdq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .pixel_value   (pixel_value),
        .cmd           (cmd),
        .status        (status),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .dilated_value (dilated_value),
        .bad_position  (bad_position)
    );

endmodule

>>> rtl/bdq_ctrl.sv
module bdq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bdq_pkg::bdq_status_t status,
    output bdq_pkg::bdq_cmd_t    cmd
);
    import bdq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.query_now && !status.bad_now)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.rsp_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> status.rsp_free)
        else $error("result loaded while output register busy");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> state_reg == ST_IDLE)
        else $error("no return to idle after result");

    a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.query_now && !status.bad_now) |=> state_reg == ST_SCAN)
        else $error("valid query did not start scan");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !status.tap_last) |=> state_reg == ST_SCAN)
        else $error("scan left before last tap");

endmodule

>>> rtl/bdq_datapath.sv
module bdq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bdq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdq_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            func,
    input  logic [bdq_pkg::DIM_W-1:0]       pixel_row,
    input  logic [bdq_pkg::DIM_W-1:0]       pixel_col,
    input  logic                            pixel_value,
    input  bdq_pkg::bdq_cmd_t               cmd,
    output bdq_pkg::bdq_status_t            status,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic                            dilated_value,
    output logic                            bad_position
);
    import bdq_pkg::*;

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [KSIZE_W-1:0] krows_reg;
    logic [KSIZE_W-1:0] kcols_reg;
    logic [KSIZE_W-1:0] crow_reg;
    logic [KSIZE_W-1:0] ccol_reg;

    logic [DIM_W-1:0]   row_reg;
    logic [DIM_W-1:0]   col_reg;
    logic               bad_reg;
    logic [KCNT_W-1:0]  kr_reg;
    logic [KCNT_W-1:0]  kc_reg;
    logic               rd_pend_reg;
    logic               mem_q_reg;
    logic               hit_reg;
    logic               rsp_valid_reg;
    logic               dilated_reg;
    logic               bad_out_reg;

    logic               store_mem [MAX_DIM*MAX_DIM];

    logic [SIZE_W-1:0]  w_sat;
    logic [SIZE_W-1:0]  h_sat;
    logic [KSIZE_W-1:0] kr_n;
    logic [KSIZE_W-1:0] kc_n;
    logic [KIDX_W-1:0]  kidx;
    logic [TAP_W-1:0]   tr;
    logic [TAP_W-1:0]   tc;
    logic               tap_on;
    logic               rd_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            mask_reg   <= RST_MASK;
            krows_reg  <= RST_KROWS;
            kcols_reg  <= RST_KCOLS;
            crow_reg   <= RST_CROW;
            ccol_reg   <= RST_CCOL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_KERNEL_MASK:  mask_reg   <= cfg_data[MASK_W-1:0];
                CFG_KERNEL_ROWS:  krows_reg  <= cfg_data[KSIZE_W-1:0];
                CFG_KERNEL_COLS:  kcols_reg  <= cfg_data[KSIZE_W-1:0];
                CFG_CENTER_ROW:   crow_reg   <= cfg_data[KSIZE_W-1:0];
                CFG_CENTER_COL:   ccol_reg   <= cfg_data[KSIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign w_sat = (width_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : width_reg;
    assign h_sat = (height_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : height_reg;
    assign kr_n  = (krows_reg > KSIZE_W'(KERNEL_MAX)) ? KSIZE_W'(KERNEL_MAX) : krows_reg;
    assign kc_n  = (kcols_reg > KSIZE_W'(KERNEL_MAX)) ? KSIZE_W'(KERNEL_MAX) : kcols_reg;

    assign status.query_now = (func == FUNC_QUERY);
    assign status.bad_now   = (SIZE_W'(pixel_row) >= h_sat) || (SIZE_W'(pixel_col) >= w_sat);
    assign status.tap_last  = (kr_reg == KCNT_W'(KERNEL_MAX - 1))
                           && (kc_reg == KCNT_W'(KERNEL_MAX - 1));
    assign status.rsp_free  = !rsp_valid_reg || rsp_ready;

    // tap offsets: position + kernel index - anchor, sign in the top bit
    assign tr   = TAP_W'(row_reg) + TAP_W'(kr_reg) - TAP_W'(crow_reg);
    assign tc   = TAP_W'(col_reg) + TAP_W'(kc_reg) - TAP_W'(ccol_reg);
    assign kidx = KIDX_W'(kr_reg) * KIDX_W'(KERNEL_MAX) + KIDX_W'(kc_reg);

    assign tap_on = (KSIZE_W'(kr_reg) < kr_n) && (KSIZE_W'(kc_reg) < kc_n)
                 && mask_reg[kidx]
                 && !tr[TAP_W-1] && (tr[SIZE_W-1:0] < h_sat)
                 && !tc[TAP_W-1] && (tc[SIZE_W-1:0] < w_sat);

    assign rd_en   = cmd.scan && tap_on;
    assign rd_addr = {tr[DIM_W-1:0], tc[DIM_W-1:0]};
    assign wr_addr = {pixel_row, pixel_col};
    assign mem_we  = cmd.load && (func == FUNC_WRITE) && !status.bad_now;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= pixel_value;
        end
        if (rd_en)
        begin
            mem_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg <= pixel_row;
            col_reg <= pixel_col;
            bad_reg <= status.bad_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg        <= '0;
            kc_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            dilated_reg   <= 1'b0;
            bad_out_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;

            if (cmd.load)
            begin
                kr_reg <= '0;
                kc_reg <= '0;
            end
            else if (cmd.scan)
            begin
                if (kc_reg == KCNT_W'(KERNEL_MAX - 1))
                begin
                    kc_reg <= '0;
                    kr_reg <= kr_reg + 1'b1;
                end
                else
                begin
                    kc_reg <= kc_reg + 1'b1;
                end
            end

            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (rd_pend_reg && mem_q_reg)
            begin
                hit_reg <= 1'b1;
            end

            if (cmd.result_load)
            begin
                rsp_valid_reg <= 1'b1;
                dilated_reg   <= hit_reg;
                bad_out_reg   <= bad_reg;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign dilated_value = dilated_reg;
    assign bad_position  = bad_out_reg;

endmodule
